>>> rtl/core/pts_pkg.sv
// package for the priority task scheduler: sizes, command codes, beat structs
// no dependencies
package pts_pkg;
  localparam int Tasks     = 16;
  localparam int Sems      = 4;
  localparam int DelayBits = 16;
  localparam int TaskW     = 4;
  localparam int SemW      = 2;
  localparam int StepW     = 10;
  localparam logic [TaskW-1:0] IdleTask = TaskW'(Tasks - 1);
  localparam logic [7:0] PostLimit = 8'd255;
  localparam logic [StepW-1:0] StepReset = StepW'(1);

  typedef enum logic [3:0] {
    CMD_READY    = 4'd0,
    CMD_SUSPEND  = 4'd1,
    CMD_RESUME   = 4'd2,
    CMD_DELAY    = 4'd3,
    CMD_TICK     = 4'd4,
    CMD_LOCK     = 4'd5,
    CMD_UNLOCK   = 4'd6,
    CMD_SEM_INIT = 4'd7,
    CMD_SEM_PEND = 4'd8,
    CMD_SEM_POST = 4'd9
  } cmd_t;

  typedef struct packed {
    logic [3:0]  command;
    logic [3:0]  task_req;
    logic        self_select;
    logic [15:0] delay_ticks;
    logic [1:0]  sem_index;
    logic [7:0]  sem_init_count;
  } in_beat_t;

  typedef struct packed {
    logic [3:0]  running_task;
    logic        switched;
    logic        granted;
    logic        resumed_after_timeout;
    logic [15:0] ready_mask;
    logic        status;
  } out_beat_t;
endpackage

>>> rtl/core/priority_task_scheduler.sv
// priority task scheduler top level: command decode, delay walk, scheduling
// depends on pts_pkg
//
//  port group | dir | beat / meaning
//  in_*       | in  | in_beat_t command beat, valid/ready
//  out_*      | out | out_beat_t result beat, valid/ready
//  cfg_*      | in  | tick_step write, no wait
//
// most commands pass from accept through exec, schedule and result states;
// a tick also passes the walk state: one shared subtract/compare unit walks the 16 delay counters
// one a cycle. the block goes back through idle before the next accept.
// the result sits in an output register; a new command waits until it is taken.
// rst_n is synchronous: idle task ready and running, all counts and waits cleared.
module priority_task_scheduler import pts_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_beat_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_beat_t        out_data,
  input  logic             cfg_we,
  input  logic [StepW-1:0] cfg_wdata
);
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_EXEC = 5'b00010,
    ST_WALK = 5'b00100,
    ST_SCHD = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  in_beat_t cmd_r;
  logic [StepW-1:0] step_r;
  logic [Tasks-1:0] ready_r;
  logic [DelayBits-1:0] dly_r [Tasks];
  logic [TaskW-1:0] run_r;
  logic lock_r;
  logic [Tasks-1:0] pwait_r;
  logic [SemW-1:0] ptgt_r [Tasks];
  logic [7:0] semv_r [Sems];
  logic [Tasks-1:0] semw_r [Sems];
  logic [TaskW-1:0] idx_r;
  logic do_sched_r, pend_r;
  out_beat_t res_r;

  // lowest set bit of the ready map
  logic [TaskW-1:0] best;
  logic             any_ready;
  always_comb begin
    best = IdleTask;
    any_ready = |ready_r;
    for (int i = Tasks - 1; i >= 0; i--)
      if (ready_r[i]) best = TaskW'(i);
  end

  logic [TaskW-1:0] waiter;
  logic [Tasks-1:0] cur_w;
  always_comb begin
    cur_w = semw_r[cmd_r.sem_index];
    waiter = '0;
    for (int i = Tasks - 1; i >= 0; i--)
      if (cur_w[i]) waiter = TaskW'(i);
  end

  // shared subtract unit used by the tick walk
  logic [DelayBits-1:0] cur_d;
  logic                 d_le;
  assign cur_d = dly_r[idx_r];
  assign d_le = cur_d <= DelayBits'(step_r);

  logic [TaskW-1:0] tgt;
  assign tgt = cmd_r.self_select ? run_r : cmd_r.task_req;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign out_data  = res_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = (cmd_r.command == CMD_TICK) ? ST_WALK : ST_SCHD;
      ST_WALK: if (idx_r == IdleTask) state_nxt = ST_SCHD;
      ST_SCHD: state_nxt = ST_OUT;
      ST_OUT:  if (out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= StepReset;
      ready_r <= Tasks'(1) << IdleTask;
      run_r   <= IdleTask;
      lock_r  <= 1'b0;
      pwait_r <= '0;
      idx_r   <= '0;
      do_sched_r <= 1'b0;
      pend_r  <= 1'b0;
      for (int i = 0; i < Tasks; i++) begin
        dly_r[i]  <= '0;
        ptgt_r[i] <= '0;
      end
      for (int s = 0; s < Sems; s++) begin
        semv_r[s] <= '0;
        semw_r[s] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) step_r <= cfg_wdata;
      unique case (state_r)
        ST_IDLE: if (in_valid) begin
          cmd_r <= in_data;
          idx_r <= '0;
          do_sched_r <= 1'b0;
          pend_r <= 1'b0;
          res_r <= '0;
        end
        ST_EXEC: begin
          unique case (cmd_r.command)
            CMD_READY: begin
              dly_r[cmd_r.task_req] <= '0;
              ready_r[cmd_r.task_req] <= 1'b1;
            end
            CMD_SUSPEND: begin
              if (tgt == IdleTask) res_r.status <= 1'b1;
              else begin
                dly_r[tgt] <= '0;
                ready_r[tgt] <= 1'b0;
                do_sched_r <= (tgt == run_r);
              end
            end
            CMD_RESUME: begin
              dly_r[cmd_r.task_req] <= '0;
              ready_r[cmd_r.task_req] <= 1'b1;
              do_sched_r <= (run_r > cmd_r.task_req);
            end
            CMD_DELAY: if (cmd_r.delay_ticks != '0) begin
              ready_r[run_r] <= 1'b0;
              dly_r[run_r] <= DelayBits'(cmd_r.delay_ticks);
              do_sched_r <= 1'b1;
            end
            CMD_TICK: do_sched_r <= 1'b1;
            CMD_LOCK: lock_r <= 1'b1;
            CMD_UNLOCK: begin
              lock_r <= 1'b0;
              do_sched_r <= 1'b1;
            end
            CMD_SEM_INIT: begin
              semv_r[cmd_r.sem_index] <= cmd_r.sem_init_count;
              semw_r[cmd_r.sem_index] <= '0;
            end
            CMD_SEM_PEND: begin
              if (semv_r[cmd_r.sem_index] != '0) begin
                semv_r[cmd_r.sem_index] <= semv_r[cmd_r.sem_index] - 8'd1;
                res_r.granted <= 1'b1;
              end else begin
                pwait_r[run_r] <= 1'b1;
                ptgt_r[run_r] <= cmd_r.sem_index;
                dly_r[run_r] <= DelayBits'(cmd_r.delay_ticks);
                semw_r[cmd_r.sem_index][run_r] <= 1'b1;
                ready_r[run_r] <= 1'b0;
                do_sched_r <= 1'b1;
                pend_r <= 1'b1;
              end
            end
            CMD_SEM_POST: begin
              if (cur_w != '0) begin
                semw_r[cmd_r.sem_index][waiter] <= 1'b0;
                ready_r[waiter] <= 1'b1;
                pwait_r[waiter] <= 1'b0;
                do_sched_r <= 1'b1;
              end else if (semv_r[cmd_r.sem_index] < PostLimit)
                semv_r[cmd_r.sem_index] <= semv_r[cmd_r.sem_index] + 8'd1;
              else
                semv_r[cmd_r.sem_index] <= '0;
            end
            default: ;
          endcase
        end
        ST_WALK: begin
          // one delay counter per cycle
          if (cur_d != '0) begin
            if (d_le) begin
              dly_r[idx_r] <= '0;
              ready_r[idx_r] <= 1'b1;
            end else dly_r[idx_r] <= cur_d - DelayBits'(step_r);
          end
          idx_r <= idx_r + TaskW'(1);
        end
        ST_SCHD: begin
          if (do_sched_r && !lock_r && any_ready && best != run_r) begin
            run_r <= best;
            res_r.switched <= 1'b1;
            res_r.running_task <= best;
            if (pwait_r[best]) begin
              semw_r[ptgt_r[best]][best] <= 1'b0;
              pwait_r[best] <= 1'b0;
              res_r.resumed_after_timeout <= 1'b1;
            end
          end else begin
            res_r.running_task <= run_r;
            // blocking pend with no switch gives up the wait at once
            if (pend_r) begin
              semw_r[cmd_r.sem_index][run_r] <= 1'b0;
              pwait_r[run_r] <= 1'b0;
            end
          end
          res_r.ready_mask <= ready_r;
        end
        ST_OUT: ;
        default: ;
      endcase
    end
  end

  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state not one-hot");
  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("accept while result pending");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped");
  a_lock: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCHD) && lock_r |=> !res_r.switched)
    else $error("switch while locked");
endmodule

>>> tb/sv/tb_top.sv
// testbench for priority_task_scheduler: directed and random command beats,
// results checked against an in-bench scheduler model; depends on pts_pkg
`timescale 1ns / 100ps

module tb_top;
  import pts_pkg::*;

  // command codes the block ignores
  localparam logic [3:0] CmdSpareLo = 4'd10;
  localparam logic [3:0] CmdSpareHi = 4'd15;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  in_beat_t         in_data;
  logic             out_valid;
  logic             out_ready;
  out_beat_t        out_data;
  logic             cfg_we;
  logic [StepW-1:0] cfg_wdata;

  priority_task_scheduler dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0; #2;
    clk = 1'b1; #2;
  end

  // scheduler model state
  logic [15:0]      m_ready;
  logic [15:0]      m_delay [Tasks];
  logic [3:0]       m_running;
  logic             m_locked;
  logic             m_pending [Tasks];
  logic [1:0]       m_pend_sem [Tasks];
  logic [7:0]       m_count [Sems];
  logic [15:0]      m_waiters [Sems];
  logic [StepW-1:0] m_step;

  out_beat_t expected_q[$];
  int        n_errors;
  int        n_checked;

  function automatic logic [3:0] lowest_task(logic [15:0] m);
    for (int i = 0; i < Tasks; i++)
      if (m[i]) return 4'(i);
    return IdleTask;
  endfunction

  function automatic logic pick_task(output logic timed_out);
    logic [3:0] best;
    timed_out = 1'b0;
    if (m_locked || m_ready == 16'h0) return 1'b0;
    best = lowest_task(m_ready);
    if (best == m_running) return 1'b0;
    m_running = best;
    if (m_pending[best]) begin
      m_waiters[m_pend_sem[best]][best] = 1'b0;
      m_pending[best] = 1'b0;
      timed_out = 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic void model_reset();
    m_ready = 16'h0;
    m_ready[IdleTask] = 1'b1;
    m_running = IdleTask;
    m_locked = 1'b0;
    m_step = StepReset;
    for (int i = 0; i < Tasks; i++) begin
      m_delay[i] = '0;
      m_pending[i] = 1'b0;
      m_pend_sem[i] = '0;
    end
    for (int s = 0; s < Sems; s++) begin
      m_count[s] = '0;
      m_waiters[s] = '0;
    end
  endfunction

  function automatic out_beat_t scheduler_step(in_beat_t b);
    out_beat_t r;
    logic sw, gr, tout, st;
    logic [3:0] tgt, me, w;
    sw = 0; gr = 0; tout = 0; st = 0;
    case (b.command)
      CMD_READY: begin
        m_delay[b.task_req] = '0;
        m_ready[b.task_req] = 1'b1;
      end
      CMD_SUSPEND: begin
        tgt = b.self_select ? m_running : b.task_req;
        if (tgt == IdleTask) st = 1'b1;
        else begin
          m_delay[tgt] = '0;
          m_ready[tgt] = 1'b0;
          if (tgt == m_running) sw = pick_task(tout);
        end
      end
      CMD_RESUME: begin
        m_delay[b.task_req] = '0;
        m_ready[b.task_req] = 1'b1;
        if (m_running > b.task_req) sw = pick_task(tout);
      end
      CMD_DELAY: begin
        if (b.delay_ticks != 0) begin
          m_ready[m_running] = 1'b0;
          m_delay[m_running] = b.delay_ticks;
          sw = pick_task(tout);
        end
      end
      CMD_TICK: begin
        for (int i = 0; i < Tasks; i++) begin
          if (m_delay[i] != 0) begin
            if ({6'h0, m_delay[i]} <= {12'h0, m_step}) m_delay[i] = '0;
            else m_delay[i] = m_delay[i] - 16'(m_step);
            if (m_delay[i] == 0) m_ready[i] = 1'b1;
          end
        end
        sw = pick_task(tout);
      end
      CMD_LOCK: m_locked = 1'b1;
      CMD_UNLOCK: begin
        m_locked = 1'b0;
        sw = pick_task(tout);
      end
      CMD_SEM_INIT: begin
        m_count[b.sem_index] = b.sem_init_count;
        m_waiters[b.sem_index] = '0;
      end
      CMD_SEM_PEND: begin
        if (m_count[b.sem_index] > 0) begin
          m_count[b.sem_index]--;
          gr = 1'b1;
        end else begin
          me = m_running;
          m_pending[me] = 1'b1;
          m_pend_sem[me] = b.sem_index;
          m_delay[me] = b.delay_ticks;
          m_waiters[b.sem_index][me] = 1'b1;
          m_ready[me] = 1'b0;
          sw = pick_task(tout);
          if (!sw) begin
            m_waiters[b.sem_index][me] = 1'b0;
            m_pending[me] = 1'b0;
          end
        end
      end
      CMD_SEM_POST: begin
        if (m_waiters[b.sem_index] != 0) begin
          w = lowest_task(m_waiters[b.sem_index]);
          m_waiters[b.sem_index][w] = 1'b0;
          m_ready[w] = 1'b1;
          m_pending[w] = 1'b0;
          sw = pick_task(tout);
        end else if (m_count[b.sem_index] < PostLimit) m_count[b.sem_index]++;
        else m_count[b.sem_index] = '0;
      end
      default: ;
    endcase
    r.running_task = m_running;
    r.switched = sw;
    r.granted = gr;
    r.resumed_after_timeout = tout;
    r.ready_mask = m_ready;
    r.status = st;
    return r;
  endfunction

  // sender: valid stays up across a zero gap, so it is driven once per edge
  task automatic send_cmd(in_beat_t b);
    int gap;
    gap = $urandom_range(0, 10);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (!in_ready);
    expected_q.push_back(scheduler_step(b));
  endtask

  task automatic send(logic [3:0] cmd, logic [3:0] t = 0, logic self = 0,
                      logic [15:0] ticks = 0, logic [1:0] s = 0,
                      logic [7:0] init = 0);
    in_beat_t b;
    b.command = cmd; b.task_req = t; b.self_select = self;
    b.delay_ticks = ticks; b.sem_index = s; b.sem_init_count = init;
    send_cmd(b);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic set_step(logic [StepW-1:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    m_step = v;
  endtask

  // result receiver and checker
  int stall;
  initial begin
    out_ready = 1'b0;
    stall = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("unexpected result beat %p", out_data);
        end else begin
          out_beat_t e;
          e = expected_q.pop_front();
          n_checked++;
          if (out_data !== e) begin
            n_errors++;
            if (n_errors <= 10)
              $display("mismatch #%0d: expected %p got %p", n_checked, e, out_data);
          end
        end
        stall = $urandom_range(0, 10);
        if ($urandom_range(0, 3) == 0) stall = 0;
      end
      if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else out_ready <= 1'b1;
    end
  end

  task automatic test_directed();
    send(CMD_SUSPEND, IdleTask);           // idle cannot be suspended
    send(CMD_SUSPEND, 0, 1);               // self resolves to idle
    send(CMD_DELAY, 0, 0, 16'd5);          // nothing else ready, no switch
    send(CMD_READY, 4'd3);
    send(CMD_RESUME, 4'd0);
    send(CMD_DELAY, 0, 0, 16'hFFFF);
    send(CMD_TICK);
    send(CMD_LOCK);
    send(CMD_RESUME, 4'd1);
    send(CMD_UNLOCK);
    send(CMD_SEM_INIT, 0, 0, 0, 2'd3, 8'd255);
    send(CMD_SEM_PEND, 0, 0, 0, 2'd3);
    send(CMD_SEM_PEND, 0, 0, 16'd2, 2'd1);  // blocks, switches away
    send(CMD_TICK);
    send(CMD_TICK);                          // pender times out
    send(CMD_SEM_POST, 0, 0, 0, 2'd1);
    send(CMD_SEM_INIT, 0, 0, 0, 2'd2, 8'd255);
    send(CMD_SEM_POST, 0, 0, 0, 2'd2);       // count wraps
    send(CmdSpareHi, 4'd15, 1, 16'hFFFF, 2'd3, 8'hFF);
    send(CmdSpareLo);
    send(CMD_SUSPEND, 4'd3);
    send(CMD_SUSPEND, 0, 1);
    send(CMD_LOCK);
    send(CMD_SEM_PEND, 0, 0, 16'd4, 2'd0);   // locked pend gives up at once
    send(CMD_UNLOCK);
  endtask

  task automatic test_random(int n);
    in_beat_t b;
    logic [63:0] raw;
    int k;
    for (int i = 0; i < n; i++) begin
      raw = {$urandom, $urandom};
      b = raw[$bits(in_beat_t)-1:0];
      k = $urandom_range(0, 99);
      if (k < 90) b.command = 4'($urandom_range(0, 9));
      if ($urandom_range(0, 3) != 0) b.delay_ticks = 16'($urandom_range(0, 6));
      if (b.command == CMD_TICK && $urandom_range(0, 2) == 0) b.command = CMD_READY;
      if ($urandom_range(0, 4) == 0) b.sem_init_count = 8'($urandom_range(0, 2));
      send_cmd(b);
      if (i == n / 2) drain();  // sender waits for all results
    end
  endtask

  initial begin
    n_errors = 0;
    n_checked = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    model_reset();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    set_step(10'd1000);
    test_random(100);
    set_step(10'd0);
    test_random(100);
    set_step(10'd1023);
    test_random(50);
    set_step(10'd2);
    test_random(150);
    set_step(10'd1);
    test_random(125);
    drain();
    if (n_errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end
endmodule
